// ===== rtl/prlc_pkg.sv =====
// ----------------------------------------------------------------------------
// prlc_pkg
// Shared widths and constants for the pixel readback layout check block.
// ----------------------------------------------------------------------------
package prlc_pkg;

    // byte address space checked against
    localparam int ADDR_WIDTH = 32;
    localparam logic [64:0] ADDR_MAX = (65'd1 << ADDR_WIDTH) - 65'd1;

    // field widths
    localparam int WORD_W  = 32;
    localparam int BPP_W   = 8;
    localparam int PIX_W   = 31;

    // stream widths
    localparam int IN_TDATA_W  = 264;
    localparam int OUT_TDATA_W = 192;
    localparam int OUT_TUSER_W = 2;

    // output tdata field offsets, lowest bit of each field
    localparam int OFS_DEST    = 0;
    localparam int OFS_ROWB    = 32;
    localparam int OFS_SCRATCH = 64;
    localparam int OFS_PACK    = 96;
    localparam int OFS_SKIPX   = 127;
    localparam int OFS_SKIPY   = 158;
    localparam int OUT_USED_W  = 189;

    // output tuser flag positions
    localparam int USER_VALID  = 0;
    localparam int USER_DIRECT = 1;

    // stride / bpp divider: stages and quotient bits per stage
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEP   = WORD_W / DIV_STAGES;

    typedef logic [DIV_STAGES-1:0] stage_en_t;

endpackage

// ===== rtl/prlc_div.sv =====
// ----------------------------------------------------------------------------
// prlc_div
// Pipelined restoring divider, 32-bit dividend by 8-bit divisor.
// ----------------------------------------------------------------------------
module prlc_div
(
    input  logic                              clk,
    input  prlc_pkg::stage_en_t               en,
    input  logic [prlc_pkg::WORD_W-1:0]       dividend,
    input  logic [prlc_pkg::BPP_W-1:0]        divisor,
    output logic [prlc_pkg::WORD_W-1:0]       quotient,
    output logic [prlc_pkg::BPP_W-1:0]        remainder
);

    // w: unused dividend bits at the top, quotient bits shifting in below
    typedef struct packed {
        logic [prlc_pkg::BPP_W-1:0]  d;
        logic [prlc_pkg::BPP_W-1:0]  r;
        logic [prlc_pkg::WORD_W-1:0] w;
    } div_t;

    div_t stage_reg  [prlc_pkg::DIV_STAGES];
    div_t stage_next [prlc_pkg::DIV_STAGES];

    function automatic div_t step_group(input div_t s);
        div_t                     o;
        logic [prlc_pkg::BPP_W:0] t;
        o = s;
        for (int i = 0; i < prlc_pkg::DIV_STEP; i++)
        begin
            t   = {o.r, o.w[prlc_pkg::WORD_W-1]};
            o.w = {o.w[prlc_pkg::WORD_W-2:0], 1'b0};
            if (t >= {1'b0, o.d})
            begin
                t      = t - {1'b0, o.d};
                o.w[0] = 1'b1;
            end
            o.r = t[prlc_pkg::BPP_W-1:0];
        end
        return o;
    endfunction

    always_comb
    begin
        stage_next[0] = step_group('{d: divisor, r: '0, w: dividend});
        for (int k = 1; k < prlc_pkg::DIV_STAGES; k++)
        begin
            stage_next[k] = step_group(stage_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < prlc_pkg::DIV_STAGES; k++)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign quotient  = stage_reg[prlc_pkg::DIV_STAGES-1].w;
    assign remainder = stage_reg[prlc_pkg::DIV_STAGES-1].r;

endmodule

// ===== rtl/pixel_readback_layout_check.sv =====
// ----------------------------------------------------------------------------
// pixel_readback_layout_check
// Validates a rectangular pixel readback request and computes its layout.
// ----------------------------------------------------------------------------
// Takes one request transaction per clock while s_tready is high and returns
// one result transaction for each, in order, through the stage 1 to 4
// registers and the output register. The depth is set by the stride /
// bytes-per-pixel divider, which resolves eight quotient bits in each of four
// stages; the range checks and the three 32x32 multiplies run alongside it,
// followed by the output register. Each stage moves on whenever the one
// after it is empty or moving, so bubbles close up and s_tready only falls
// once every stage holds a transaction and m_tready is low. A rejected
// request comes back with valid_res low and every other field zero; the pack
// fields are non-zero only when the read area is pixel aligned and the
// stride is a whole number of pixels.
// ----------------------------------------------------------------------------
module pixel_readback_layout_check
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: buffer_length[31:0], stride_bytes[63:32], row_offset[95:64],
    //          row_bytes[127:96], bytes_per_pixel[135:128], origin_x[167:136],
    //          origin_y[199:168], read_width[231:200], read_height[263:232]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [prlc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // m_tdata: dest_offset[31:0], copy_row_bytes[63:32], scratch_bytes[95:64],
    //          pack_row_length[126:96], skip_pixels[157:127],
    //          skip_rows[188:158], zero pad[191:189]
    // m_tuser: valid_res[0], direct[1]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [prlc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [prlc_pkg::OUT_TUSER_W-1:0]     m_tuser
);

    typedef struct packed {
        logic        bad;
        logic [32:0] row_end;
        logic [31:0] bottom_row;
        logic [31:0] stride;
        logic [31:0] rbytes;
        logic [30:0] h;
        logic [30:0] oy;
        logic [30:0] ox;
        logic [31:0] roff;
        logic [31:0] blen;
        logic        dir_ok;
    } st1_t;

    typedef struct packed {
        logic        bad;
        logic [32:0] row_end;
        logic [63:0] last_start;
        logic [63:0] scratch;
        logic [31:0] doff;
        logic [31:0] roff;
        logic [31:0] blen;
        logic [31:0] rbytes;
        logic [30:0] ox;
        logic [30:0] oy;
        logic        dir_ok;
    } st2_t;

    typedef struct packed {
        logic        bad;
        logic [31:0] dest;
        logic [31:0] rbytes;
        logic [31:0] scratch;
        logic [30:0] ox;
        logic [30:0] oy;
        logic        dir_ok;
    } st3_t;

    // request fields
    logic [31:0] blen_in, stride_in, roff_in, rbytes_in;
    logic [7:0]  bpp_in;
    logic [31:0] ox_in, oy_in, w_in, h_in;

    assign blen_in   = s_tdata[31:0];
    assign stride_in = s_tdata[63:32];
    assign roff_in   = s_tdata[95:64];
    assign rbytes_in = s_tdata[127:96];
    assign bpp_in    = s_tdata[135:128];
    assign ox_in     = s_tdata[167:136];
    assign oy_in     = s_tdata[199:168];
    assign w_in      = s_tdata[231:200];
    assign h_in      = s_tdata[263:232];

    // stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4, en_out;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st3_t s4_reg;

    logic [31:0] quo;
    logic [7:0]  rem;

    logic                               m_tvalid_reg;
    logic [prlc_pkg::OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [prlc_pkg::OUT_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    assign en_out   = !m_tvalid_reg || m_tready;
    assign en4      = !v4_reg || en_out;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: zero and range checks, row end, last row, alignment products
    always_comb
    begin
        logic [32:0] row_end;
        logic [39:0] ox_bytes;
        logic [39:0] w_bytes;
        row_end  = {1'b0, roff_in} + {1'b0, rbytes_in};
        ox_bytes = 40'(ox_in) * 40'(bpp_in);
        w_bytes  = 40'(w_in) * 40'(bpp_in);

        s1_next.bad      = (stride_in == '0) || (rbytes_in == '0) || (bpp_in == '0)
                        || (w_in == '0) || (h_in == '0)
                        || ox_in[31] || oy_in[31] || w_in[31] || h_in[31]
                        || ({32'd0, row_end} > prlc_pkg::ADDR_MAX)
                        || (row_end > {1'b0, stride_in});
        s1_next.row_end    = row_end;
        s1_next.bottom_row = oy_in + h_in - 32'd1;
        s1_next.stride   = stride_in;
        s1_next.rbytes   = rbytes_in;
        s1_next.h        = h_in[30:0];
        s1_next.oy       = oy_in[30:0];
        s1_next.ox       = ox_in[30:0];
        s1_next.roff     = roff_in;
        s1_next.blen     = blen_in;
        s1_next.dir_ok   = (ox_bytes == 40'(roff_in)) && (w_bytes == 40'(rbytes_in));
    end

    // stage 2: the three multiplies
    always_comb
    begin
        s2_next.bad        = s1_reg.bad;
        s2_next.row_end    = s1_reg.row_end;
        s2_next.last_start = {32'd0, s1_reg.bottom_row} * {32'd0, s1_reg.stride};
        s2_next.scratch    = {32'd0, s1_reg.rbytes} * {33'd0, s1_reg.h};
        s2_next.doff       = {1'b0, s1_reg.oy} * s1_reg.stride;
        s2_next.roff       = s1_reg.roff;
        s2_next.blen       = s1_reg.blen;
        s2_next.rbytes     = s1_reg.rbytes;
        s2_next.ox         = s1_reg.ox;
        s2_next.oy         = s1_reg.oy;
        s2_next.dir_ok     = s1_reg.dir_ok;
    end

    // stage 3: end of last row against address space and buffer, scratch size, dest offset
    always_comb
    begin
        logic [64:0] last_end;
        // row_end is within the address space here unless already rejected,
        // so a last row end inside it also covers its start
        last_end = {1'b0, s2_reg.last_start} + {32'd0, s2_reg.row_end};

        s3_next.bad     = s2_reg.bad
                       || (last_end > prlc_pkg::ADDR_MAX)
                       || (last_end > {33'd0, s2_reg.blen})
                       || ({1'b0, s2_reg.scratch} > prlc_pkg::ADDR_MAX);
        s3_next.dest    = s2_reg.doff + s2_reg.roff;
        s3_next.rbytes  = s2_reg.rbytes;
        s3_next.scratch = s2_reg.scratch[31:0];
        s3_next.ox      = s2_reg.ox;
        s3_next.oy      = s2_reg.oy;
        s3_next.dir_ok  = s2_reg.dir_ok;
    end

    prlc_div u_div
    (
        .clk       (clk),
        .en        ({en4, en3, en2, en1}),
        .dividend  (stride_in),
        .divisor   (bpp_in),
        .quotient  (quo),
        .remainder (rem)
    );

    // result formation into the output register
    always_comb
    begin
        logic ok;
        logic dir;
        ok  = !s4_reg.bad;
        dir = ok && s4_reg.dir_ok && (rem == '0) && !quo[31];

        m_tdata_next = '0;
        if (ok)
        begin
            m_tdata_next[prlc_pkg::OFS_DEST    +: 32] = s4_reg.dest;
            m_tdata_next[prlc_pkg::OFS_ROWB    +: 32] = s4_reg.rbytes;
            m_tdata_next[prlc_pkg::OFS_SCRATCH +: 32] = s4_reg.scratch;
        end
        if (dir)
        begin
            m_tdata_next[prlc_pkg::OFS_PACK  +: 31] = quo[30:0];
            m_tdata_next[prlc_pkg::OFS_SKIPX +: 31] = s4_reg.ox;
            m_tdata_next[prlc_pkg::OFS_SKIPY +: 31] = s4_reg.oy;
        end
        m_tuser_next                        = '0;
        m_tuser_next[prlc_pkg::USER_VALID]  = ok;
        m_tuser_next[prlc_pkg::USER_DIRECT] = dir;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_out)
            begin
                m_tvalid_reg <= v4_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
        if (en4)
        begin
            s4_reg <= s3_reg;
        end
        if (en_out)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/prlc_checker.sv =====
// ----------------------------------------------------------------------------
// prlc_checker
// Port-level assertions for the pixel readback layout check block.
// ----------------------------------------------------------------------------
module prlc_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [prlc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic [prlc_pkg::OUT_TUSER_W-1:0]     m_tuser
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a ready receiver always lets a new request in
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with the output ready");

    // rejected request carries all-zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[prlc_pkg::USER_VALID]
            |-> (m_tdata == '0) && !m_tuser[prlc_pkg::USER_DIRECT])
        else $error("rejected result with non-zero fields");

    // accepted request always copies at least one byte per row and has a non-zero scratch size
    a_rowb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[prlc_pkg::USER_VALID]
            |-> (m_tdata[prlc_pkg::OFS_ROWB +: 32] != '0)
             && (m_tdata[prlc_pkg::OFS_SCRATCH +: 32] != '0))
        else $error("accepted result with empty rows");

    // pack fields and pad bits clear whenever a result is not direct
    a_pack_gated: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[prlc_pkg::USER_DIRECT]
            |-> (m_tdata[prlc_pkg::OUT_TDATA_W-1:prlc_pkg::OFS_PACK] == '0))
        else $error("pack fields set on a non-direct result");

endmodule

bind pixel_readback_layout_check prlc_checker u_prlc_checker (.*);
